// ===== sv/spsc_pkg.sv =====
// Shared types and constants for the segmented prime sieve counter.
// No dependencies; used by segmented_prime_sieve_counter.
`timescale 1ns / 1ps
`default_nettype none

package spsc_pkg;

    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 13;
    localparam int MARK_AW    = 16;
    localparam int MARK_DEPTH = 1 << MARK_AW;
    localparam int BASE_AW    = 6;
    localparam int BASE_DEPTH = 1 << BASE_AW;
    localparam int ROOT_W     = 8;
    localparam int TOTAL_W    = BASE_AW + 1;
    localparam int IDX_W      = LIMIT_W + 1;

    localparam logic [LIMIT_W-1:0] MIN_LIMIT   = 16'd2;
    localparam logic [COUNT_W-1:0] COUNT_BOUND = 13'd6542;

    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ROOT_W-1:0]  root_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [IDX_W-1:0]   idx_t;

endpackage

`default_nettype wire

// ===== sv/segmented_prime_sieve_counter.sv =====
// Segmented prime sieve counter: counts the primes in 2..N for one limit N; uses spsc_pkg.
// One beat in flight at a time.
// Throughput is set by the single-port mark memory: one mark or count step per cycle.
// Reset: asynchronous, active low; after reset a clearing pass sweeps all 65536 entries of the
// mark memory while busy stays high. Results are strobed for one cycle (no stall).
`timescale 1ns / 1ps
`default_nettype none

module segmented_prime_sieve_counter #(
    parameter int unsigned MAX_LIMIT = 65535
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire spsc_pkg::limit_t limit,
    output logic                  done,
    output spsc_pkg::count_t      prime_count
);

    // Sequencer states
    localparam logic [3:0] S_CLR   = 4'd0;   // sweep mark memory after reset
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;   // bit-serial floor square root
    localparam logic [3:0] S_BRD   = 4'd3;   // base sieve: read mark of i
    localparam logic [3:0] S_BCHK  = 4'd4;   // base sieve: test mark of i
    localparam logic [3:0] S_BMARK = 4'd5;   // base sieve: mark multiples of i
    localparam logic [3:0] S_SRD   = 4'd6;   // segment: fetch base prime k
    localparam logic [3:0] S_SP    = 4'd7;   // segment: square the prime
    localparam logic [3:0] S_SMARK = 4'd8;   // segment: mark multiples
    localparam logic [3:0] S_CNT   = 4'd9;   // count unmarked, clear behind

    localparam logic [23:0] MAX_LIMIT_W = 24'(MAX_LIMIT);

    // Mark memory: base range and segment share it (they never overlap).
    logic                         marks [spsc_pkg::MARK_DEPTH];
    logic                         mark_rdata_reg;
    logic                         mark_we;
    logic [spsc_pkg::MARK_AW-1:0] mark_addr;
    logic                         mark_wdata;

    // Base prime store
    logic [spsc_pkg::ROOT_W-1:0]  base_mem [spsc_pkg::BASE_DEPTH];
    spsc_pkg::root_t              bp_rdata_reg;
    logic                         bp_we;

    logic [3:0]        state_reg, state_next;
    spsc_pkg::limit_t  n_reg, n_next;
    spsc_pkg::root_t   root_reg, root_next;
    logic [2:0]        bit_reg, bit_next;
    logic [8:0]        i_reg, i_next;
    spsc_pkg::idx_t    j_reg, j_next;
    spsc_pkg::root_t   p_reg, p_next;
    spsc_pkg::total_t  k_reg, k_next;
    spsc_pkg::total_t  total_reg, total_next;
    spsc_pkg::count_t  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              done_reg, done_next;
    spsc_pkg::count_t  prime_count_reg, prime_count_next;

    spsc_pkg::limit_t  n_sat;
    spsc_pkg::idx_t    n_ext;
    spsc_pkg::idx_t    seg_lo;
    spsc_pkg::root_t   trial;
    logic [15:0]       trial_sq;
    logic              accept;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign prime_count = prime_count_reg;
    assign accept      = start && !busy;

    // Saturate the limit to the configured maximum.
    assign n_sat  = ({8'd0, limit} > MAX_LIMIT_W) ? spsc_pkg::LIMIT_W'(MAX_LIMIT) : limit;
    assign n_ext  = {1'b0, n_reg};
    assign seg_lo = spsc_pkg::IDX_W'(root_reg) + spsc_pkg::IDX_W'(1);

    assign trial    = root_reg | (spsc_pkg::ROOT_W'(1) << bit_reg);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        root_next        = root_reg;
        bit_next         = bit_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        p_next           = p_reg;
        k_next           = k_reg;
        total_next       = total_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        done_next        = 1'b0;
        prime_count_next = prime_count_reg;
        mark_we          = 1'b0;
        mark_addr        = j_reg[spsc_pkg::MARK_AW-1:0];
        mark_wdata       = 1'b0;
        bp_we            = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                // Clear one entry per cycle until the top address.
                mark_we = 1'b1;
                j_next  = j_reg + spsc_pkg::IDX_W'(1);
                if (&j_reg[spsc_pkg::MARK_AW-1:0])
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (n_sat < spsc_pkg::MIN_LIMIT)
                    begin
                        // No primes below two: answer at once.
                        done_next        = 1'b1;
                        prime_count_next = '0;
                    end
                    else
                    begin
                        n_next     = n_sat;
                        root_next  = '0;
                        bit_next   = 3'd7;
                        i_next     = 9'd2;
                        total_next = '0;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                // Keep the trial bit if its square still fits under N.
                if (trial_sq <= n_reg)
                begin
                    root_next = trial;
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                if (i_reg > {1'b0, root_reg})
                begin
                    k_next     = '0;
                    state_next = S_SRD;
                end
                else
                begin
                    // Read the mark and clear it behind the read.
                    mark_addr  = spsc_pkg::MARK_AW'(i_reg);
                    mark_we    = 1'b1;
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if (!mark_rdata_reg)
                begin
                    if (total_reg < spsc_pkg::TOTAL_W'(spsc_pkg::BASE_DEPTH))
                    begin
                        bp_we      = 1'b1;
                        total_next = total_reg + spsc_pkg::TOTAL_W'(1);
                    end
                    j_next     = spsc_pkg::IDX_W'({i_reg, 1'b0});
                    state_next = S_BMARK;
                end
                else
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_BRD;
                end
            end
            S_BMARK:
            begin
                if (j_reg > spsc_pkg::IDX_W'(root_reg))
                begin
                    i_next     = i_reg + 9'd1;
                    state_next = S_BRD;
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_wdata = 1'b1;
                    j_next     = j_reg + spsc_pkg::IDX_W'(i_reg);
                end
            end
            S_SRD:
            begin
                if (k_reg == total_reg)
                begin
                    j_next     = seg_lo;
                    state_next = S_CNT;
                end
                else
                begin
                    state_next = S_SP;
                end
            end
            S_SP:
            begin
                p_next     = bp_rdata_reg;
                j_next     = spsc_pkg::IDX_W'(16'(bp_rdata_reg) * 16'(bp_rdata_reg));
                state_next = S_SMARK;
            end
            S_SMARK:
            begin
                if (j_reg > n_ext)
                begin
                    k_next     = k_reg + spsc_pkg::TOTAL_W'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    // Skip multiples that fall in the base range.
                    if (j_reg >= seg_lo)
                    begin
                        mark_we    = 1'b1;
                        mark_wdata = 1'b1;
                    end
                    j_next = j_reg + spsc_pkg::IDX_W'(p_reg);
                end
            end
            S_CNT:
            begin
                // Issue a read per cycle; clear each entry as it is read.
                if (j_reg <= n_ext)
                begin
                    mark_we   = 1'b1;
                    pend_next = 1'b1;
                    j_next    = j_reg + spsc_pkg::IDX_W'(1);
                end
                if (pend_reg && !mark_rdata_reg)
                begin
                    cnt_next = cnt_reg + spsc_pkg::COUNT_W'(1);
                end
                if ((j_reg > n_ext) && !pend_reg)
                begin
                    done_next        = 1'b1;
                    prime_count_next = cnt_reg + spsc_pkg::COUNT_W'(total_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            j_reg     <= '0;
            total_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        root_reg        <= root_next;
        bit_reg         <= bit_next;
        i_reg           <= i_next;
        p_reg           <= p_next;
        k_reg           <= k_next;
        prime_count_reg <= prime_count_next;
    end

    // Mark memory: read-first, one access address per cycle.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            marks[mark_addr] <= mark_wdata;
        end
        mark_rdata_reg <= marks[mark_addr];
    end

    // Base prime store: write at the fill count, read at k.
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            base_mem[total_reg[spsc_pkg::BASE_AW-1:0]] <= i_reg[spsc_pkg::ROOT_W-1:0];
        end
        bp_rdata_reg <= base_mem[k_reg[spsc_pkg::BASE_AW-1:0]];
    end

    // A result only follows work in progress or a beat just taken.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE || start))
        else $error("result strobe without a beat");

    // A taken beat either starts work or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat dropped");

    // No range up to 65535 holds more primes than this.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prime_count <= spsc_pkg::COUNT_BOUND))
        else $error("prime count out of range");

endmodule

`default_nettype wire
